// ===== sv/bfsp_pkg.sv =====
// Shared types, constants and control structs of the best-fit surface pool.
package bfsp_pkg;

  localparam int FREE_DEPTH      = 16;
  localparam int BUSY_DEPTH      = 16;
  localparam int DIM_MAX         = 4096;
  localparam int FREE_IDX_W      = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int BUSY_IDX_W      = (BUSY_DEPTH > 1) ? $clog2(BUSY_DEPTH) : 1;
  localparam int FREE_CNT_W      = $clog2(FREE_DEPTH + 1);
  localparam int BUSY_CNT_W      = $clog2(BUSY_DEPTH + 1);
  localparam int HANDLE_W        = 16;
  localparam int DIM_W           = 13;
  localparam int BYTES_W         = 32;
  localparam int BUDGET_W        = 28;
  localparam int AREA_W          = 2 * DIM_W;
  localparam int COST_W          = 2 * DIM_W + 1;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 28'd7340032;

  typedef enum logic [2:0] {
    EV_HIT      = 3'd0,
    EV_CREATED  = 3'd1,
    EV_FAILED   = 3'd2,
    EV_RELEASED = 3'd3,
    EV_EVICTED  = 3'd4,
    EV_REJECTED = 3'd5
  } ev_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_SQ,
    S_SCAN_CMP,
    S_PICK,
    S_HIT,
    S_MISS_MUL,
    S_MISS_ADD,
    S_EV_CHK,
    S_EV_MUL,
    S_EV_OUT,
    S_CREATE,
    S_REL,
    S_REJ
  } state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
  } entry_t;

  typedef struct packed {
    logic accept_en;
    logic scan_clr;
    logic scan_rd;
    logic scan_sq;
    logic scan_cmp;
    logic miss_mul;
    logic miss_add;
    logic ev_mul;
    logic ev_out;
    logic hit;
    logic create;
    logic rel;
    logic rej;
  } cmd_t;

  typedef struct packed {
    logic                  in_fire;
    logic                  kind;
    logic                  bad;
    logic                  busy_full;
    logic                  busy_empty;
    logic                  free_full;
    logic                  free_empty;
    logic                  scan_last;
    logic                  found;
    logic                  over;
    logic                  out_free;
    logic [FREE_CNT_W-1:0] free_cnt;
    logic [BUSY_CNT_W-1:0] busy_cnt;
  } status_t;

endpackage

// ===== sv/bfsp_if.sv =====
// Channel interfaces of the pool: request, result and budget write.
interface bfsp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [bfsp_pkg::DIM_W-1:0]    req_width;
  logic [bfsp_pkg::DIM_W-1:0]    req_height;
  logic [bfsp_pkg::HANDLE_W-1:0] new_handle;
  logic                          create_ok;
  modport source (output valid, kind, req_width, req_height, new_handle, create_ok,
                  input ready);
  modport sink (input valid, kind, req_width, req_height, new_handle, create_ok,
                output ready);
endinterface

interface bfsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    event_res;
  logic [bfsp_pkg::HANDLE_W-1:0] handle;
  logic [bfsp_pkg::DIM_W-1:0]    buf_width;
  logic [bfsp_pkg::DIM_W-1:0]    buf_height;
  logic [bfsp_pkg::BYTES_W-1:0]  memory_used;
  logic                          last;
  modport source (output valid, event_res, handle, buf_width, buf_height, memory_used,
                  last, input ready);
  modport sink (input valid, event_res, handle, buf_width, buf_height, memory_used,
                last, output ready);
endinterface

interface bfsp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfsp_pkg::BUDGET_W-1:0] memory_budget;
  modport source (output valid, memory_budget, input ready);
  modport sink (input valid, memory_budget, output ready);
endinterface

// ===== sv/bfsp_ctrl.sv =====
// Sequencer of the pool: steps scan, miss, eviction and result beats.
module bfsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfsp_pkg::status_t st_i,
  output bfsp_pkg::cmd_t    cmd_o
);
  import bfsp_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (st_i.in_fire) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!st_i.kind) begin
          if (st_i.bad || st_i.busy_full) state_d = S_REJ;
          else if (st_i.free_empty)       state_d = S_MISS_MUL;
          else                            state_d = S_SCAN_RD;
        end else begin
          if (st_i.busy_empty)     state_d = S_REJ;
          else if (st_i.free_full) state_d = S_EV_MUL;
          else                     state_d = S_REL;
        end
      end
      S_SCAN_RD:  state_d = S_SCAN_SQ;
      S_SCAN_SQ:  state_d = S_SCAN_CMP;
      S_SCAN_CMP: state_d = st_i.scan_last ? S_PICK : S_SCAN_RD;
      S_PICK:     state_d = st_i.found ? S_HIT : S_MISS_MUL;
      S_HIT: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      S_MISS_MUL: state_d = S_MISS_ADD;
      S_MISS_ADD: state_d = S_EV_CHK;
      S_EV_CHK: begin
        state_d = (!st_i.free_empty && st_i.over) ? S_EV_MUL : S_CREATE;
      end
      S_EV_MUL:   state_d = S_EV_OUT;
      S_EV_OUT: begin
        if (st_i.out_free) state_d = st_i.kind ? S_REL : S_EV_CHK;
      end
      S_CREATE, S_REL, S_REJ: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:     cmd_o.accept_en = 1'b1;
      S_CHECK:    cmd_o.scan_clr  = 1'b1;
      S_SCAN_RD:  cmd_o.scan_rd   = 1'b1;
      S_SCAN_SQ:  cmd_o.scan_sq   = 1'b1;
      S_SCAN_CMP: cmd_o.scan_cmp  = 1'b1;
      S_PICK:     cmd_o = '0;
      S_HIT:      cmd_o.hit       = st_i.out_free;
      S_MISS_MUL: cmd_o.miss_mul  = 1'b1;
      S_MISS_ADD: cmd_o.miss_add  = 1'b1;
      S_EV_CHK:   cmd_o = '0;
      S_EV_MUL:   cmd_o.ev_mul    = 1'b1;
      S_EV_OUT:   cmd_o.ev_out    = st_i.out_free;
      S_CREATE:   cmd_o.create    = st_i.out_free;
      S_REL:      cmd_o.rel       = st_i.out_free;
      S_REJ:      cmd_o.rej       = st_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

endmodule

// ===== sv/bfsp_dp.sv =====
// Datapath of the pool: free list, busy stack, byte count and result register.
module bfsp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfsp_pkg::cmd_t    cmd_i,
  output bfsp_pkg::status_t st_o,
  bfsp_in_if.sink           in_i,
  bfsp_out_if.source        out_o,
  bfsp_cfg_if.sink          cfg_i
);
  import bfsp_pkg::*;

  entry_t free_q [FREE_DEPTH];
  entry_t busy_q [BUSY_DEPTH];
  logic [FREE_CNT_W-1:0] free_cnt_q;
  logic [BUSY_CNT_W-1:0] busy_cnt_q;
  logic [BYTES_W-1:0]    bytes_q, bytes_d;
  logic [BUDGET_W-1:0]   budget_q;

  // Latched request.
  logic                kind_q, ok_q;
  logic [DIM_W-1:0]    rw_q, rh_q;
  logic [HANDLE_W-1:0] nh_q;

  // Scan and arithmetic registers.
  logic [FREE_IDX_W-1:0] idx_q, best_q;
  logic                  found_q, fit_q;
  logic [DIM_W-1:0]      dw_q, dh_q;
  logic [AREA_W-1:0]     sqw_q, sqh_q, need_q, evb_q;
  logic [COST_W-1:0]     best_cost_q, cost;

  // Result register.
  logic                out_valid_q;
  ev_e                 ev_q;
  entry_t              oe_q;
  logic [BYTES_W-1:0]  omem_q;
  logic                olast_q;

  entry_t                cur, pop_e;
  logic                  in_fire, out_free;
  logic [BUSY_IDX_W-1:0] top_idx;
  logic                  emit;

  assign in_fire  = in_i.valid && cmd_i.accept_en;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = cmd_i.accept_en;
  assign cfg_i.ready = 1'b1;
  assign cur      = free_q[idx_q];
  assign top_idx  = BUSY_IDX_W'(busy_cnt_q - BUSY_CNT_W'(1));
  assign pop_e    = busy_q[top_idx];
  assign cost     = COST_W'(sqw_q) + COST_W'(sqh_q);
  assign emit     = cmd_i.hit || cmd_i.ev_out || cmd_i.create || cmd_i.rel || cmd_i.rej;

  // Status toward the sequencer.
  always_comb begin
    st_o.in_fire    = in_fire;
    st_o.kind       = kind_q;
    st_o.bad        = (rw_q == '0) || (rh_q == '0) ||
                      (rw_q > DIM_W'(DIM_MAX)) || (rh_q > DIM_W'(DIM_MAX));
    st_o.busy_full  = busy_cnt_q >= BUSY_CNT_W'(BUSY_DEPTH);
    st_o.busy_empty = busy_cnt_q == '0;
    st_o.free_full  = free_cnt_q >= FREE_CNT_W'(FREE_DEPTH);
    st_o.free_empty = free_cnt_q == '0;
    st_o.scan_last  = (FREE_CNT_W'(idx_q) + FREE_CNT_W'(1)) >= free_cnt_q;
    st_o.found      = found_q;
    st_o.over       = bytes_q > BYTES_W'(budget_q);
    st_o.out_free   = out_free;
    st_o.free_cnt   = free_cnt_q;
    st_o.busy_cnt   = busy_cnt_q;
  end

  // Next byte count.
  always_comb begin
    bytes_d = bytes_q;
    if (cmd_i.miss_add)                 bytes_d = bytes_q + BYTES_W'({need_q, 2'b00});
    else if (cmd_i.ev_out)              bytes_d = bytes_q - BYTES_W'({evb_q, 2'b00});
    else if (cmd_i.create && !ok_q)     bytes_d = bytes_q - BYTES_W'({need_q, 2'b00});
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q  <= '0;
      busy_cnt_q  <= '0;
      bytes_q     <= '0;
      budget_q    <= BUDGET_RESET;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cfg_i.valid) budget_q <= cfg_i.memory_budget;
      bytes_q <= bytes_d;
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_cmp) begin
        idx_q <= idx_q + FREE_IDX_W'(1);
        if (fit_q && (!found_q || cost < best_cost_q)) found_q <= 1'b1;
      end
      if (cmd_i.hit) begin
        free_cnt_q <= free_cnt_q - FREE_CNT_W'(1);
        busy_cnt_q <= busy_cnt_q + BUSY_CNT_W'(1);
      end else if (cmd_i.ev_out) begin
        free_cnt_q <= free_cnt_q - FREE_CNT_W'(1);
      end else if (cmd_i.create && ok_q) begin
        busy_cnt_q <= busy_cnt_q + BUSY_CNT_W'(1);
      end else if (cmd_i.rel) begin
        free_cnt_q <= free_cnt_q + FREE_CNT_W'(1);
        busy_cnt_q <= busy_cnt_q - BUSY_CNT_W'(1);
      end
      if (emit)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // Request latch, scan arithmetic and size products.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_i.kind;
      rw_q   <= in_i.req_width;
      rh_q   <= in_i.req_height;
      nh_q   <= in_i.new_handle;
      ok_q   <= in_i.create_ok;
    end
    if (cmd_i.scan_rd) begin
      fit_q <= (cur.w >= rw_q) && (cur.h >= rh_q);
      dw_q  <= cur.w - rw_q;
      dh_q  <= cur.h - rh_q;
    end
    if (cmd_i.scan_sq) begin
      sqw_q <= AREA_W'(dw_q) * AREA_W'(dw_q);
      sqh_q <= AREA_W'(dh_q) * AREA_W'(dh_q);
    end
    if (cmd_i.scan_cmp && fit_q && (!found_q || cost < best_cost_q)) begin
      best_cost_q <= cost;
      best_q      <= idx_q;
    end
    if (cmd_i.miss_mul) need_q <= AREA_W'(rw_q) * AREA_W'(rh_q);
    if (cmd_i.ev_mul)   evb_q  <= AREA_W'(free_q[0].w) * AREA_W'(free_q[0].h);
  end

  // Free list: removal closes the gap toward the oldest end, release appends.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < FREE_DEPTH - 1; j++) begin
      if ((cmd_i.hit && FREE_IDX_W'(j) >= best_q) || cmd_i.ev_out) begin
        free_q[j] <= free_q[j+1];
      end
    end
    if (cmd_i.rel) free_q[FREE_IDX_W'(free_cnt_q)] <= pop_e;
  end

  // Busy stack pushes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hit) begin
      busy_q[BUSY_IDX_W'(busy_cnt_q)] <= free_q[best_q];
    end else if (cmd_i.create && ok_q) begin
      busy_q[BUSY_IDX_W'(busy_cnt_q)] <= '{handle: nh_q, w: rw_q, h: rh_q};
    end
  end

  // Result beat payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      omem_q  <= bytes_d;
      olast_q <= !cmd_i.ev_out;
      if (cmd_i.hit) begin
        ev_q <= EV_HIT;
        oe_q <= free_q[best_q];
      end else if (cmd_i.ev_out) begin
        ev_q <= EV_EVICTED;
        oe_q <= free_q[0];
      end else if (cmd_i.create) begin
        ev_q <= ok_q ? EV_CREATED : EV_FAILED;
        oe_q <= ok_q ? entry_t'{handle: nh_q, w: rw_q, h: rh_q} : '0;
      end else if (cmd_i.rel) begin
        ev_q <= EV_RELEASED;
        oe_q <= pop_e;
      end else begin
        ev_q <= EV_REJECTED;
        oe_q <= '0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_res   = ev_q;
  assign out_o.handle      = oe_q.handle;
  assign out_o.buf_width   = oe_q.w;
  assign out_o.buf_height  = oe_q.h;
  assign out_o.memory_used = omem_q;
  assign out_o.last        = olast_q;

endmodule

// ===== sv/best_fit_surface_pool.sv =====
// Top level of the best-fit surface pool: sequencer, datapath and checks.
// The pool takes one request beat at a time and answers with one to seventeen
// result beats, the final one flagged by last. A new request is taken once the
// previous one has issued its final beat, even while that beat still waits in
// the output register. An acquire walks the free list one entry at a time with
// a read, a square and a compare step per entry; a miss then computes the
// needed bytes and evicts the oldest free entries while over budget, and a
// release first evicts the oldest free entry when the free list is full. A
// stalled result side holds the sequencer at the next beat. The budget may be
// rewritten only while the pool is idle; there is no clearing pass after reset.
module best_fit_surface_pool (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfsp_in_if.sink    in_i,
  bfsp_out_if.source out_o,
  bfsp_cfg_if.sink   cfg_i
);
  import bfsp_pkg::*;

  cmd_t    cmd;
  status_t st;

  bfsp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  bfsp_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .st_o   (st),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

  // A result beat is only produced when the output register can take it.
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.hit || cmd.ev_out || cmd.create || cmd.rel || cmd.rej) |-> st.out_free)
    else $error("result produced while output register is occupied");

  // The counts never exceed the storage depths.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st.free_cnt <= FREE_CNT_W'(FREE_DEPTH)) && (st.busy_cnt <= BUSY_CNT_W'(BUSY_DEPTH)))
    else $error("pool count out of range");

  // The pool is not ready in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.in_fire |=> !in_i.ready)
    else $error("request taken while previous one in work");

  // A release never appends to a full free list nor pops an empty busy stack.
  a_rel_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rel |-> !st.free_full && !st.busy_empty)
    else $error("release with no room or empty stack");

endmodule
